@@ hdl/tpcc_pkg.sv @@
// Shared constants, types and helper functions for the three-prime CRT combine core.
// Holds the moduli, the Garner constants and the constant sets for the Barrett multipliers.
// No dependencies; used by tpcc_modmul and three_prime_crt_combine_core.
package tpcc_pkg;

    // Pipeline depth from input register to output register
    localparam int NUM_STAGES = 20;

    // Residue primes and output modulus (all 30 bits wide)
    localparam logic [29:0] PRIME_0 = 30'd998244353;
    localparam logic [29:0] PRIME_1 = 30'd897581057;
    localparam logic [29:0] PRIME_2 = 30'd754974721;
    localparam logic [29:0] OUT_MOD = 30'd1000000007;

    // Garner constants: P0^-1 mod P1 and (P0*P1)^-1 mod P2
    localparam logic [29:0] INV_P0_MOD_P1  = 30'd523588941;
    localparam logic [29:0] INV_P01_MOD_P2 = 30'd59724183;

    // Radix weights reduced into the modulus they are used with
    localparam logic [29:0] P0_MOD_P2 = 30'(64'(PRIME_0) % 64'(PRIME_2));
    localparam logic [29:0] P0_MOD_Q  = 30'(64'(PRIME_0) % 64'(OUT_MOD));
    localparam logic [29:0] P01_MOD_Q = 30'((64'(PRIME_0) * 64'(PRIME_1)) % 64'(OUT_MOD));

    // Barrett reciprocals floor(2^60 / m); every modulus lies in (2^29, 2^30)
    localparam logic [30:0] MU_P1 = 31'((64'd1 << 60) / 64'(PRIME_1));
    localparam logic [30:0] MU_P2 = 31'((64'd1 << 60) / 64'(PRIME_2));
    localparam logic [30:0] MU_Q  = 31'((64'd1 << 60) / 64'(OUT_MOD));

    // Which constant multiply a modmul instance performs
    typedef enum logic [2:0] {
        MM_DIGIT1,      // d1 * P0^-1 mod P1
        MM_DIGIT1_P2,   // v1 * P0 mod P2
        MM_DIGIT1_Q,    // v1 * P0 mod Q
        MM_DIGIT2,      // d2 * (P0*P1)^-1 mod P2
        MM_DIGIT2_Q     // v2 * P0*P1 mod Q
    } mm_op_t;

    typedef struct packed {
        logic [29:0] modulus;
        logic [29:0] factor;
        logic [30:0] mu;
    } mm_const_t;

    // Look up modulus, constant factor and reciprocal for one multiply kind
    function automatic mm_const_t mm_const(mm_op_t op);
        mm_const_t k;
        case (op)
            MM_DIGIT1:    k = '{modulus: PRIME_1, factor: INV_P0_MOD_P1,  mu: MU_P1};
            MM_DIGIT1_P2: k = '{modulus: PRIME_2, factor: P0_MOD_P2,      mu: MU_P2};
            MM_DIGIT1_Q:  k = '{modulus: OUT_MOD, factor: P0_MOD_Q,       mu: MU_Q};
            MM_DIGIT2:    k = '{modulus: PRIME_2, factor: INV_P01_MOD_P2, mu: MU_P2};
            MM_DIGIT2_Q:  k = '{modulus: OUT_MOD, factor: P01_MOD_Q,      mu: MU_Q};
            default:      k = '{modulus: PRIME_1, factor: INV_P0_MOD_P1,  mu: MU_P1};
        endcase
        return k;
    endfunction

    // Reduce a value below 2*m into [0, m)
    function automatic logic [29:0] fold_mod2(logic [30:0] val, logic [29:0] modulus);
        logic [30:0] m1;
        m1 = {1'b0, modulus};
        if (val >= m1) begin
            return 30'(val - m1);
        end
        return val[29:0];
    endfunction

    // Reduce a value below 3*m into [0, m)
    function automatic logic [29:0] fold_mod3(logic [31:0] val, logic [29:0] modulus);
        logic [31:0] m1;
        logic [31:0] m2;
        m1 = {2'b00, modulus};
        m2 = {1'b0, modulus, 1'b0};
        if (val >= m2) begin
            return 30'(val - m2);
        end else if (val >= m1) begin
            return 30'(val - m1);
        end
        return val[29:0];
    endfunction

endpackage

@@ hdl/tpcc_modmul.sv @@
// Four-stage modular multiply by a constant: product, Barrett quotient, remainder, fold.
// The constant set is picked by a tpcc_pkg::mm_op_t code that is tied off at the instance.
// Depends on tpcc_pkg.
module tpcc_modmul (
    input  logic               aclk,
    input  tpcc_pkg::mm_op_t   op,
    input  logic [3:0]         adv,          // per-stage load enables, bit 0 first
    input  logic [29:0]        operand_in,
    output logic [29:0]        product_out
);

    tpcc_pkg::mm_const_t k;

    logic [59:0] prod_reg;
    logic [59:0] prod_next;
    logic [31:0] lo_reg;
    logic [61:0] qh_reg;
    logic [61:0] qh_next;
    logic [31:0] rem_reg;
    logic [31:0] rem_next;
    logic [29:0] res_reg;
    logic [29:0] res_next;

    assign k = tpcc_pkg::mm_const(op);

    // Full product, then estimated quotient from its top 31 bits
    assign prod_next = 60'(operand_in) * 60'(k.factor);
    assign qh_next   = 62'(prod_reg[59:29]) * 62'(k.mu);

    // Remainder is below 3m, so the low 32 bits are enough
    assign rem_next  = lo_reg - (32'(qh_reg[61:31]) * 32'(k.modulus));
    assign res_next  = tpcc_pkg::fold_mod3(rem_reg, k.modulus);

    // Advance each stage when the pipeline control lets it
    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            prod_reg <= prod_next;
        end
        if (adv[1]) begin
            qh_reg <= qh_next;
            lo_reg <= prod_reg[31:0];
        end
        if (adv[2]) begin
            rem_reg <= rem_next;
        end
        if (adv[3]) begin
            res_reg <= res_next;
        end
    end

    assign product_out = res_reg;

endmodule

@@ hdl/three_prime_crt_combine_core.sv @@
// Top level of the three-prime CRT combine core: Garner reconstruction, result mod 1e9+7.
// Twenty register stages with valid bits; five tpcc_modmul units do the constant multiplies.
// Depends on tpcc_pkg and tpcc_modmul.
//
//  channel | dir | word layout (low bit first)                       | handshake
//  --------+-----+---------------------------------------------------+----------------
//  s_      | in  | residue_p0[29:0], residue_p1[59:30], residue_p2    | tvalid & tready
//          |     | [89:60], zero pad [95:90]                          |
//  m_      | out | coefficient_out[29:0], zero pad [31:30]            | tvalid & tready
//
// One word enters per cycle while s_tready is high; each word passes through stages 0 to 19
// on its way to m_. The depth is set by the chain of four Barrett multipliers in series,
// four stages each. Reset clears the valid bits only. A stall at m_ holds the output word;
// empty stages behind it keep filling, so s_tready drops only when every stage is full.
module three_prime_crt_combine_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,     // residue_p0, residue_p1, residue_p2, zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata      // coefficient_out, zero pad
);

    localparam int NS = tpcc_pkg::NUM_STAGES;

    logic [NS-1:0] vld_reg;
    logic [NS-1:0] vld_next;
    logic [NS:0]   ready;

    // Stage payload registers
    logic [29:0] r0_reg;
    logic [29:0] r1_reg;
    logic [29:0] r2_reg   [0:9];
    logic [29:0] v0_reg   [1:18];
    logic [29:0] v0m2_reg [1:9];
    logic [29:0] d1_reg;
    logic [29:0] d2_reg;
    logic [29:0] a_reg    [10:18];
    logic [29:0] x_reg;

    logic [29:0] r0_next;
    logic [29:0] r1_next;
    logic [29:0] r2_next;
    logic [29:0] v0m1;
    logic [29:0] v0m2_next;
    logic [29:0] d1_next;
    logic [31:0] d2_sum;
    logic [29:0] d2_next;
    logic [31:0] x_sum;
    logic [29:0] x_next;

    // Multiplier results
    logic [29:0] v1;
    logic [29:0] w;
    logic [29:0] a_st9;
    logic [29:0] v2;
    logic [29:0] b;

    // Stage ready: a stage loads when it is empty or the one after it moves
    always_comb begin
        ready[NS] = m_tready;
        for (int i = NS - 1; i >= 0; i--) begin
            ready[i] = !vld_reg[i] || ready[i+1];
        end
    end

    assign s_tready = ready[0];

    // Shift valid bits along with the data
    always_comb begin
        vld_next[0] = ready[0] ? s_tvalid : vld_reg[0];
        for (int i = 1; i < NS; i++) begin
            vld_next[i] = ready[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // Stage 0: bring each residue below its prime
    assign r0_next = tpcc_pkg::fold_mod2(31'(s_tdata[29:0]),  tpcc_pkg::PRIME_0);
    assign r1_next = tpcc_pkg::fold_mod2(31'(s_tdata[59:30]), tpcc_pkg::PRIME_1);
    assign r2_next = tpcc_pkg::fold_mod2(31'(s_tdata[89:60]), tpcc_pkg::PRIME_2);

    // Stage 1: first Garner difference, and v0 mod P2 for later
    assign v0m1      = tpcc_pkg::fold_mod2(31'(r0_reg), tpcc_pkg::PRIME_1);
    assign v0m2_next = tpcc_pkg::fold_mod2(31'(r0_reg), tpcc_pkg::PRIME_2);
    assign d1_next   = tpcc_pkg::fold_mod2(31'(r1_reg) + 31'(tpcc_pkg::PRIME_1) - 31'(v0m1),
                                           tpcc_pkg::PRIME_1);

    // Stage 10: second Garner difference r2 - v0 - v1*P0 mod P2, biased by 2*P2
    assign d2_sum  = 32'(r2_reg[9]) + {1'b0, tpcc_pkg::PRIME_2, 1'b0}
                     - 32'(v0m2_reg[9]) - 32'(w);
    assign d2_next = tpcc_pkg::fold_mod3(d2_sum, tpcc_pkg::PRIME_2);

    // Stage 19: add the three radix terms mod Q
    assign x_sum  = 32'(v0_reg[18]) + 32'(a_reg[18]) + 32'(b);
    assign x_next = tpcc_pkg::fold_mod3(x_sum, tpcc_pkg::OUT_MOD);

    // Payload registers; carried values shift with their stage
    always_ff @(posedge aclk) begin
        if (ready[0]) begin
            r0_reg    <= r0_next;
            r1_reg    <= r1_next;
            r2_reg[0] <= r2_next;
        end
        if (ready[1]) begin
            d1_reg      <= d1_next;
            v0_reg[1]   <= r0_reg;
            v0m2_reg[1] <= v0m2_next;
        end
        for (int i = 1; i <= 9; i++) begin
            if (ready[i]) begin
                r2_reg[i] <= r2_reg[i-1];
            end
        end
        for (int i = 2; i <= 9; i++) begin
            if (ready[i]) begin
                v0m2_reg[i] <= v0m2_reg[i-1];
            end
        end
        for (int i = 2; i <= 18; i++) begin
            if (ready[i]) begin
                v0_reg[i] <= v0_reg[i-1];
            end
        end
        if (ready[10]) begin
            d2_reg     <= d2_next;
            a_reg[10]  <= a_st9;
        end
        for (int i = 11; i <= 18; i++) begin
            if (ready[i]) begin
                a_reg[i] <= a_reg[i-1];
            end
        end
        if (ready[19]) begin
            x_reg <= x_next;
        end
    end

    // Stages 2-5: v1 = d1 * P0^-1 mod P1
    tpcc_modmul u_digit1 (
        .aclk        (aclk),
        .op          (tpcc_pkg::MM_DIGIT1),
        .adv         (ready[5:2]),
        .operand_in  (d1_reg),
        .product_out (v1)
    );

    // Stages 6-9: v1 * P0 mod P2 for the second digit
    tpcc_modmul u_digit1_p2 (
        .aclk        (aclk),
        .op          (tpcc_pkg::MM_DIGIT1_P2),
        .adv         (ready[9:6]),
        .operand_in  (v1),
        .product_out (w)
    );

    // Stages 6-9: v1 * P0 mod Q for the output sum
    tpcc_modmul u_digit1_q (
        .aclk        (aclk),
        .op          (tpcc_pkg::MM_DIGIT1_Q),
        .adv         (ready[9:6]),
        .operand_in  (v1),
        .product_out (a_st9)
    );

    // Stages 11-14: v2 = d2 * (P0*P1)^-1 mod P2
    tpcc_modmul u_digit2 (
        .aclk        (aclk),
        .op          (tpcc_pkg::MM_DIGIT2),
        .adv         (ready[14:11]),
        .operand_in  (d2_reg),
        .product_out (v2)
    );

    // Stages 15-18: v2 * P0*P1 mod Q
    tpcc_modmul u_digit2_q (
        .aclk        (aclk),
        .op          (tpcc_pkg::MM_DIGIT2_Q),
        .adv         (ready[18:15]),
        .operand_in  (v2),
        .product_out (b)
    );

    assign m_tvalid = vld_reg[NS-1];
    assign m_tdata  = {2'b00, x_reg};

    // Result always lies below the output modulus
    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[29:0] < tpcc_pkg::OUT_MOD))
        else $error("coefficient_out not reduced below Q");

    // First Garner difference is reduced
    a_d1_range: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[1] |-> (d1_reg < tpcc_pkg::PRIME_1))
        else $error("d1 not reduced below P1");

    // Second Garner difference is reduced
    a_d2_range: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[10] |-> (d2_reg < tpcc_pkg::PRIME_2))
        else $error("d2 not reduced below P2");

    // Words in flight change only by accepted inputs and delivered outputs
    a_occupancy: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |->
            ($countones(vld_reg) == $countones($past(vld_reg))
                + $past(s_tvalid && s_tready) - $past(m_tvalid && m_tready)))
        else $error("pipeline lost or duplicated a word");

endmodule
